// File: rtl/core/rcfe_pkg.sv
`default_nettype none

package rcfe_pkg;

    localparam int FRAME_BYTES = 5;
    localparam int IDX_W       = $clog2(FRAME_BYTES);

    // binary to bcd conversion of the set-frequency word
    localparam int BIN_W      = 32;
    localparam int BCD_DIGITS = 10;
    localparam int ITER_W     = $clog2(BIN_W);

    // reply decode walks eight nibbles
    localparam int NIB_STEPS = 8;

    localparam logic [7:0]  OP_QUERY    = 8'h03;
    localparam logic [7:0]  OP_SET_FREQ = 8'h01;
    localparam logic [7:0]  OP_SET_MODE = 8'h07;
    localparam logic [7:0]  BYTE_ZERO   = 8'h00;
    localparam logic [29:0] FREQ_MAX    = 30'd999999990;

    typedef enum logic [1:0] {
        CMD_RX       = 2'd0,
        CMD_QUERY    = 2'd1,
        CMD_SET_FREQ = 2'd2,
        CMD_SET_MODE = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BCD,
        ST_DEC,
        ST_SCALE,
        ST_SEND
    } state_t;

    typedef struct packed {
        logic load;
        logic bcd_step;
        logic dec_step;
        logic dec_finish;
        logic advance;
    } rcfe_cmd_t;

    typedef struct packed {
        logic reply_full;
        logic bcd_done;
        logic dec_done;
        logic out_last;
    } rcfe_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/rcfe_ctrl.sv
`default_nettype none

module rcfe_ctrl
    import rcfe_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire cmd_t       cmd,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output rcfe_cmd_t       dp_cmd,
    input  wire rcfe_stat_t dp_stat
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (cmd == CMD_SET_FREQ)
                    begin
                        state_next = ST_BCD;
                    end
                    else if (cmd == CMD_RX && dp_stat.reply_full)
                    begin
                        state_next = ST_DEC;
                    end
                    else
                    begin
                        state_next = ST_SEND;
                    end
                end
            end
            ST_BCD:
            begin
                if (dp_stat.bcd_done)
                begin
                    state_next = ST_SEND;
                end
            end
            ST_DEC:
            begin
                if (dp_stat.dec_done)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (m_tready && dp_stat.out_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready          = (state_reg == ST_IDLE);
        m_tvalid          = (state_reg == ST_SEND);
        dp_cmd.load       = (state_reg == ST_IDLE) && s_tvalid;
        dp_cmd.bcd_step   = (state_reg == ST_BCD);
        dp_cmd.dec_step   = (state_reg == ST_DEC);
        dp_cmd.dec_finish = (state_reg == ST_SCALE);
        dp_cmd.advance    = (state_reg == ST_SEND) && m_tready;
    end

endmodule

`default_nettype wire

// File: rtl/core/rcfe_datapath.sv
`default_nettype none

module rcfe_datapath
    import rcfe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cmd_t        cmd,
    input  wire logic [7:0]  rx_byte,
    input  wire logic [31:0] set_frequency,
    input  wire logic [7:0]  set_mode,
    input  wire rcfe_cmd_t   dp_cmd,
    output rcfe_stat_t       dp_stat,
    output logic [7:0]       tx_byte,
    output logic             tx_valid,
    output logic             last,
    output logic [29:0]      cached_frequency,
    output logic             frequency_valid,
    output logic [7:0]       cached_mode,
    output logic             mode_valid
);

    // cache and reply tracking
    logic        armed_reg;
    logic [2:0]  count_reg;
    logic [7:0]  digits_reg [4];
    logic [29:0] freq_store_reg;
    logic        freq_known_reg;
    logic [7:0]  mode_store_reg;
    logic        mode_known_reg;

    // per-item work registers
    cmd_t                  cmd_reg;
    logic [7:0]            mode_in_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [ITER_W-1:0]     iter_reg;
    logic [BIN_W-1:0]      bin_reg;
    logic [4*BCD_DIGITS-1:0] bcd_reg;
    logic [31:0]           nib_reg;
    logic [31:0]           acc_reg;

    logic [4*BCD_DIGITS-1:0] bcd_adj;
    logic [31:0]           acc_step;
    logic [31:0]           acc_scaled;
    logic [29:0]           freq_sat;
    logic [5:0]            bcd_lsb;

    // add-3 correction on every digit before the shift
    always_comb
    begin
        for (int d = 0; d < BCD_DIGITS; d++)
        begin
            bcd_adj[4*d +: 4] = (bcd_reg[4*d +: 4] >= 4'd5) ? bcd_reg[4*d +: 4] + 4'd3
                                                            : bcd_reg[4*d +: 4];
        end
    end

    assign acc_step   = {acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0}
                      + {28'd0, nib_reg[31:28]};
    assign acc_scaled = {acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0};
    assign freq_sat   = (acc_scaled > {2'b00, FREQ_MAX}) ? FREQ_MAX : acc_scaled[29:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg      <= 1'b0;
            count_reg      <= 3'd0;
            freq_store_reg <= 30'd0;
            freq_known_reg <= 1'b0;
            mode_store_reg <= 8'd0;
            mode_known_reg <= 1'b0;
            idx_reg        <= '0;
            iter_reg       <= '0;
        end
        else
        begin
            if (dp_cmd.load)
            begin
                idx_reg  <= '0;
                iter_reg <= '0;
                unique case (cmd)
                    CMD_RX:
                    begin
                        if (armed_reg)
                        begin
                            if (count_reg < 3'd4)
                            begin
                                count_reg <= count_reg + 3'd1;
                            end
                            else
                            begin
                                mode_store_reg <= rx_byte;
                                mode_known_reg <= 1'b1;
                                armed_reg      <= 1'b0;
                                count_reg      <= 3'd0;
                            end
                        end
                    end
                    CMD_QUERY:
                    begin
                        armed_reg <= 1'b1;
                    end
                    CMD_SET_FREQ:
                    begin
                        freq_known_reg <= 1'b0;
                    end
                    CMD_SET_MODE:
                    begin
                        mode_known_reg <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (dp_cmd.bcd_step || dp_cmd.dec_step)
            begin
                iter_reg <= iter_reg + ITER_W'(1);
            end
            if (dp_cmd.dec_finish)
            begin
                freq_store_reg <= freq_sat;
                freq_known_reg <= 1'b1;
            end
            if (dp_cmd.advance && !dp_stat.out_last)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            cmd_reg     <= cmd;
            mode_in_reg <= set_mode;
            bin_reg     <= set_frequency;
            bcd_reg     <= '0;
            acc_reg     <= 32'd0;
            nib_reg     <= {digits_reg[0], digits_reg[1], digits_reg[2], digits_reg[3]};
            if (cmd == CMD_RX && armed_reg && count_reg < 3'd4)
            begin
                digits_reg[count_reg[1:0]] <= rx_byte;
            end
        end
        if (dp_cmd.bcd_step)
        begin
            bcd_reg <= {bcd_adj[4*BCD_DIGITS-2:0], bin_reg[BIN_W-1]};
            bin_reg <= {bin_reg[BIN_W-2:0], 1'b0};
        end
        if (dp_cmd.dec_step)
        begin
            acc_reg <= acc_step;
            nib_reg <= {nib_reg[27:0], 4'h0};
        end
    end

    assign dp_stat.reply_full = armed_reg && (count_reg == 3'd4);
    assign dp_stat.bcd_done   = (iter_reg == ITER_W'(BIN_W - 1));
    assign dp_stat.dec_done   = (iter_reg == ITER_W'(NIB_STEPS - 1));
    assign dp_stat.out_last   = (cmd_reg == CMD_RX) || (idx_reg == IDX_W'(FRAME_BYTES - 1));

    // low bit of the digit pair sent in frame byte idx
    assign bcd_lsb = 6'd28 - {idx_reg, 3'b000};

    // frame byte select; bcd digit 8 is the 100 MHz digit
    always_comb
    begin
        tx_byte  = BYTE_ZERO;
        tx_valid = 1'b1;
        unique case (cmd_reg)
            CMD_RX:
            begin
                tx_valid = 1'b0;
            end
            CMD_QUERY:
            begin
                if (idx_reg == IDX_W'(FRAME_BYTES - 1))
                begin
                    tx_byte = OP_QUERY;
                end
            end
            CMD_SET_FREQ:
            begin
                if (idx_reg == IDX_W'(FRAME_BYTES - 1))
                begin
                    tx_byte = OP_SET_FREQ;
                end
                else
                begin
                    tx_byte = bcd_reg[bcd_lsb +: 8];
                end
            end
            CMD_SET_MODE:
            begin
                if (idx_reg == IDX_W'(FRAME_BYTES - 1))
                begin
                    tx_byte = OP_SET_MODE;
                end
                else if (idx_reg == '0)
                begin
                    tx_byte = mode_in_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign last             = dp_stat.out_last;
    assign cached_frequency = freq_known_reg ? freq_store_reg : 30'd0;
    assign frequency_valid  = freq_known_reg;
    assign cached_mode      = mode_known_reg ? mode_store_reg : 8'd0;
    assign mode_valid       = mode_known_reg;

endmodule

`default_nettype wire

// File: rtl/core/radio_cat_frame_engine.sv
// Radio control-link engine. Each command transfer on the slave side yields one
// five-byte frame on the master side, one byte per transfer with tlast on the fifth;
// a received byte (cmd 0) yields a single transfer with tuser low that carries the
// cached frequency and mode. Items are handled one at a time: a query, set-mode or
// received byte is accepted and then sent out; set-frequency first runs a bit-serial
// binary to bcd conversion; the byte that completes a reply first runs a nibble-serial
// decode (8 multiply-by-ten steps and a final scale with saturation).
`default_nettype none

module radio_cat_frame_engine
    import rcfe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // rx_byte, set_frequency, set_mode
    input  wire logic [1:0]  s_tuser,   // cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0] m_tdata, // tx_byte, cached_frequency, frequency_valid, cached_mode, mode_valid
    output logic             m_tuser,   // tx_valid
    output logic             m_tlast
);

    rcfe_cmd_t  dp_cmd;
    rcfe_stat_t dp_stat;
    cmd_t       cmd;

    logic [7:0]  tx_byte;
    logic [29:0] cached_frequency;
    logic        frequency_valid;
    logic [7:0]  cached_mode;
    logic        mode_valid;

    assign cmd = cmd_t'(s_tuser);

    rcfe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .dp_cmd   (dp_cmd),
        .dp_stat  (dp_stat)
    );

    rcfe_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .rx_byte          (s_tdata[7:0]),
        .set_frequency    (s_tdata[39:8]),
        .set_mode         (s_tdata[47:40]),
        .dp_cmd           (dp_cmd),
        .dp_stat          (dp_stat),
        .tx_byte          (tx_byte),
        .tx_valid         (m_tuser),
        .last             (m_tlast),
        .cached_frequency (cached_frequency),
        .frequency_valid  (frequency_valid),
        .cached_mode      (cached_mode),
        .mode_valid       (mode_valid)
    );

    assign m_tdata = {mode_valid, cached_mode, frequency_valid, cached_frequency, tx_byte};

endmodule

`default_nettype wire

// File: tb/sv/tb_radio_cat_frame_engine.sv
`timescale 1ns / 100ps

module tb_radio_cat_frame_engine;
    import rcfe_pkg::*;

    localparam int IDLE_LIMIT = 3000;

    class frame_tracker;
        typedef struct {
            logic [7:0]  tx_byte;
            logic        tx_valid;
            logic        last;
            logic [29:0] freq;
            logic        freq_ok;
            logic [7:0]  mode;
            logic        mode_ok;
        } frame_beat_t;

        frame_beat_t pending_beats[$];
        bit          armed;
        bit [2:0]    rx_count;
        bit [7:0]    digits[4];
        bit [29:0]   freq_store;
        bit          freq_known;
        bit [7:0]    mode_store;
        bit          mode_known;
        int          mismatches;

        function new();
            armed      = 1'b0;
            rx_count   = '0;
            freq_store = '0;
            freq_known = 1'b0;
            mode_store = '0;
            mode_known = 1'b0;
            mismatches = 0;
        endfunction

        // eight nibbles, high nibble first, in units of 10 Hz
        function bit [29:0] decode_reply();
            bit [31:0] acc;
            bit [3:0]  nib;
            acc = '0;
            for (int i = 0; i < 8; i++)
            begin
                nib = i[0] ? digits[i >> 1][3:0] : digits[i >> 1][7:4];
                acc = acc * 10 + nib;
            end
            acc = acc * 10;
            if (acc > FREQ_MAX)
                acc = FREQ_MAX;
            return acc[29:0];
        endfunction

        function void push_beat(bit [7:0] tx, bit valid, bit last);
            frame_beat_t beat;
            beat.tx_byte  = tx;
            beat.tx_valid = valid;
            beat.last     = last;
            beat.freq     = freq_known ? freq_store : '0;
            beat.freq_ok  = freq_known;
            beat.mode     = mode_known ? mode_store : '0;
            beat.mode_ok  = mode_known;
            pending_beats.push_back(beat);
        endfunction

        // returns 0 when the item had no effect on the block
        function bit note_command(cmd_t c, bit [7:0] rx, bit [31:0] f, bit [7:0] m);
            bit [7:0]  frame[5];
            bit [3:0]  dec[10];
            bit [31:0] v;
            bit        effect;
            effect = 1'b1;
            if (c == CMD_RX)
            begin
                if (!armed)
                    effect = 1'b0;
                else if (rx_count < 4)
                begin
                    digits[rx_count[1:0]] = rx;
                    rx_count++;
                end
                else
                begin
                    mode_store = rx;
                    mode_known = 1'b1;
                    freq_store = decode_reply();
                    freq_known = 1'b1;
                    armed      = 1'b0;
                    rx_count   = '0;
                end
                push_beat(BYTE_ZERO, 1'b0, 1'b1);
            end
            else
            begin
                case (c)
                    CMD_QUERY:
                    begin
                        armed = 1'b1;
                        frame = '{BYTE_ZERO, BYTE_ZERO, BYTE_ZERO, BYTE_ZERO, OP_QUERY};
                    end
                    CMD_SET_FREQ:
                    begin
                        v = f;
                        for (int i = 9; i >= 0; i--)
                        begin
                            dec[i] = 4'(v % 10);
                            v      = v / 10;
                        end
                        // 1 GHz and 1 Hz digits fall off the ends
                        for (int i = 0; i < 4; i++)
                            frame[i] = {dec[1 + 2 * i], dec[2 + 2 * i]};
                        frame[4]   = OP_SET_FREQ;
                        freq_known = 1'b0;
                    end
                    default:
                    begin
                        frame      = '{m, BYTE_ZERO, BYTE_ZERO, BYTE_ZERO, OP_SET_MODE};
                        mode_known = 1'b0;
                    end
                endcase
                for (int k = 0; k < FRAME_BYTES; k++)
                    push_beat(frame[k], 1'b1, k == FRAME_BYTES - 1);
            end
            return effect;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_output(logic [47:0] data, logic tv, logic tl);
            frame_beat_t want;
            if (pending_beats.size() == 0)
            begin
                $error("unexpected output transfer: tdata %h", data);
                mismatches++;
                return;
            end
            want = pending_beats.pop_front();
            compare_field("tx_byte", want.tx_byte, data[7:0]);
            compare_field("cached_frequency", want.freq, data[37:8]);
            compare_field("frequency_valid", want.freq_ok, data[38]);
            compare_field("cached_mode", want.mode, data[46:39]);
            compare_field("mode_valid", want.mode_ok, data[47]);
            compare_field("tx_valid", want.tx_valid, tv);
            compare_field("last", want.last, tl);
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = CMD_RX;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    frame_tracker board = new();
    bit           quiet   = 1'b0;
    int           counted = 0;

    radio_cat_frame_engine uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // fields the command does not use get random filler
    task automatic send_cmd(cmd_t c, bit [31:0] val);
        int       gap;
        bit [7:0] rx;
        bit [31:0] f;
        bit [7:0] m;
        rx = 8'($urandom);
        f  = $urandom;
        m  = 8'($urandom);
        case (c)
            CMD_RX:       rx = val[7:0];
            CMD_SET_FREQ: f  = val;
            CMD_SET_MODE: m  = val[7:0];
            default:      ;
        endcase
        gap = quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {m, f, rx};
        s_tuser  <= c;
        do @(posedge clk); while (!s_tready);
        if (board.note_command(c, rx, f, m))
            counted++;
    endtask

    // first byte sits in the top bits
    task automatic send_reply(bit [39:0] bytes);
        for (int i = 4; i >= 0; i--)
            send_cmd(CMD_RX, bytes[i * 8 +: 8]);
    endtask

    task automatic wait_results();
        s_tvalid <= 1'b0;
        while (board.pending_beats.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            board.check_output(m_tdata, m_tuser, m_tlast);
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        wait (rst_n === 1'b1);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int        next_phase;
        bit        paused;
        bit [31:0] val;
        cmd_t      c;
        next_phase = 40;
        paused     = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // byte with no reply armed is dropped
        send_cmd(CMD_RX, 32'hA5);
        send_cmd(CMD_SET_FREQ, 32'h0000_0000);
        send_cmd(CMD_SET_FREQ, 32'hFFFF_FFFF);
        send_cmd(CMD_SET_MODE, 32'h00);
        send_cmd(CMD_SET_MODE, 32'hFF);
        send_cmd(CMD_QUERY, 0);
        send_reply(40'h14_25_00_00_02);
        // query and set commands in the middle of a reply keep it armed
        send_cmd(CMD_QUERY, 0);
        send_cmd(CMD_RX, 32'h07);
        send_cmd(CMD_RX, 32'h09);
        send_cmd(CMD_QUERY, 0);
        send_cmd(CMD_SET_FREQ, 32'd999_999_999);
        send_cmd(CMD_SET_MODE, 32'h5A);
        send_cmd(CMD_RX, 32'h99);
        send_cmd(CMD_RX, 32'h10);
        send_cmd(CMD_RX, 32'h81);
        // non-bcd nibbles overflow and saturate
        send_cmd(CMD_QUERY, 0);
        send_reply(40'hFF_FF_FF_FF_FF);
        wait_results();

        while (counted < 380)
        begin
            if (counted >= next_phase)
            begin
                quiet       = ($urandom_range(0, 3) == 0);
                next_phase += 40;
            end
            if (!paused && counted >= 200)
            begin
                paused = 1'b1;
                wait_results();
            end
            if ($urandom_range(0, 9) < 6)
            begin
                send_cmd(CMD_QUERY, 0);
                for (int i = 0; i < 5; i++)
                begin
                    if ($urandom_range(0, 15) == 0)
                        break;
                    if ($urandom_range(0, 7) == 0)
                        send_cmd(cmd_t'($urandom_range(1, 3)), $urandom);
                    if ($urandom_range(0, 3) == 0)
                        val = $urandom;
                    else
                        val = {24'd0, 4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
                    send_cmd(CMD_RX, val);
                end
            end
            else
            begin
                c = cmd_t'($urandom_range(0, 3));
                if (c == CMD_SET_FREQ && $urandom_range(0, 2) == 0)
                    val = $urandom_range(0, 999_999_999);
                else
                    val = $urandom;
                send_cmd(c, val);
            end
        end

        wait_results();
        repeat (60) @(posedge clk);
        if (board.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
